[rtl/qfm_pkg.sv]
// Shared types and codes for the quasistatic frequency model.
// No dependencies; imported by the channel interfaces and the top level.
package qfm_pkg;

    typedef logic [1:0]  func_t;
    typedef logic [2:0]  status_t;
    typedef logic [15:0] freq_t;
    typedef logic [16:0] ival_t;

    localparam func_t FUNC_MARK = 2'd0;
    localparam func_t FUNC_INIT = 2'd1;
    localparam func_t FUNC_ENC  = 2'd2;
    localparam func_t FUNC_DEC  = 2'd3;

    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_BAD_SYM = 3'd1;
    localparam status_t ST_BAD_CUM = 3'd2;
    localparam status_t ST_NO_INIT = 3'd3;
    localparam status_t ST_NO_USED = 3'd4;

    localparam logic [1:0] REG_NUM_SYMBOLS = 2'd0;
    localparam logic [1:0] REG_TARGET      = 2'd1;
    localparam logic [1:0] REG_LG_TOTAL    = 2'd2;

    localparam freq_t TOTAL_FULL = 16'hFFFF;
    localparam freq_t TOTAL_MIN  = 16'd256;

    // total frequency for a log total; below 8 mean 256, 16 and above mean 65535
    function automatic freq_t eff_total(input logic [4:0] lg);
        freq_t t;
        if (lg >= 5'd16)
        begin
            t = TOTAL_FULL;
        end
        else if (lg < 5'd8)
        begin
            t = TOTAL_MIN;
        end
        else
        begin
            t = freq_t'(17'd1 << lg);
        end
        return t;
    endfunction

endpackage

[rtl/qfm_in_if.sv]
// Input channel of the frequency model: valid/ready plus one request beat.
// Depends on qfm_pkg.
interface qfm_in_if import qfm_pkg::*; ();
    logic       valid;
    logic       ready;
    func_t      func;
    logic [7:0] symbol;
    logic       used;
    freq_t      cum_freq;

    modport source(output valid, func, symbol, used, cum_freq, input ready);
    modport sink(input valid, func, symbol, used, cum_freq, output ready);
endinterface

[rtl/qfm_out_if.sv]
// Output channel of the frequency model: valid/ready plus one result beat.
// Depends on qfm_pkg.
interface qfm_out_if import qfm_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] symbol_out;
    freq_t      sym_freq;
    freq_t      low_freq;
    status_t    status;

    modport source(output valid, symbol_out, sym_freq, low_freq, status, input ready);
    modport sink(input valid, symbol_out, sym_freq, low_freq, status, output ready);
endinterface

[rtl/qfm_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module qfm_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/qfm_div.sv]
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module qfm_div #(
    parameter int W = 17
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic         done,
    output logic [W-1:0] quot,
    output logic [W-1:0] rem
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  q_reg;
    logic [W-1:0]  r_reg;
    logic [W-1:0]  d_reg;
    logic [W:0]    sh;
    logic [W:0]    diff;
    logic          ge;

    assign sh   = {r_reg, q_reg[W-1]};
    assign ge   = sh >= {1'b0, d_reg};
    assign diff = sh - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[W-2:0], ge};
            r_reg <= ge ? diff[W-1:0] : sh[W-1:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

[rtl/quasistatic_frequency_model.sv]
// Quasistatic frequency model: one request beat in, one result beat out.
// Decode adds to the encode path a binary search over the cumulative RAM, a search and
// a compare state per step, plus one closing search state. A rescale either releases
// the deferred remainder or walks the pending RAM once and waits on the divider; init
// adds a count and a fill sweep. One request is in flight
// at a time; a result may wait in the output register while the next request is taken.
// Reset is asynchronous (rst_n); RAMs are not cleared, control state and the used-mark
// valid bits are.
module quasistatic_frequency_model import qfm_pkg::*; #(
    parameter int MAX_SYMBOLS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    qfm_in_if.sink      in_ch,
    qfm_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_SYMBOLS);
    localparam int NW = $clog2(MAX_SYMBOLS + 1);
    localparam logic [NW-1:0] NMAX = NW'(MAX_SYMBOLS);

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_CNT    = 5'd2;
    localparam logic [4:0] S_CNT_E  = 5'd3;
    localparam logic [4:0] S_CHK    = 5'd4;
    localparam logic [4:0] S_DIVI   = 5'd5;
    localparam logic [4:0] S_FILL   = 5'd6;
    localparam logic [4:0] S_FILL_E = 5'd7;
    localparam logic [4:0] S_REB    = 5'd8;
    localparam logic [4:0] S_WALK   = 5'd9;
    localparam logic [4:0] S_WALK_E = 5'd10;
    localparam logic [4:0] S_CTOP   = 5'd11;
    localparam logic [4:0] S_DIVM   = 5'd12;
    localparam logic [4:0] S_SRCH   = 5'd13;
    localparam logic [4:0] S_SCMP   = 5'd14;
    localparam logic [4:0] S_FETCH  = 5'd15;
    localparam logic [4:0] S_GRAB   = 5'd16;
    localparam logic [4:0] S_UPD    = 5'd17;
    localparam logic [4:0] S_PADD   = 5'd18;
    localparam logic [4:0] S_RESULT = 5'd19;

    // config registers
    logic [8:0]  ns_reg, ns_next;
    ival_t       tr_reg, tr_next;
    logic [4:0]  lg_reg, lg_next;

    // model state
    logic        init_reg, init_next;
    ival_t       ri_reg, ri_next;
    ival_t       ul_reg, ul_next;
    ival_t       dl_reg, dl_next;
    freq_t       inc_reg, inc_next;
    logic [MAX_SYMBOLS-1:0] uvld_reg;

    // sequencer
    logic [4:0]    state_reg, state_next;
    func_t         fn_reg, fn_next;
    logic [7:0]    sym_reg, sym_next;
    logic          mark_reg, mark_next;
    freq_t         cumin_reg, cumin_next;
    logic [NW-1:0] k_reg, k_next;
    logic [NW-1:0] kd_reg, kd_next;
    logic          pv_reg, pv_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    freq_t         share_reg, share_next;
    logic [NW-1:0] extra_reg, extra_next;
    freq_t         run_reg, run_next;
    freq_t         mis_reg, mis_next;
    logic          neg_reg, neg_next;
    logic          frinit_reg, frinit_next;
    logic [NW-1:0] lo_reg, lo_next;
    logic [NW-1:0] hi_reg, hi_next;
    logic [NW-1:0] mid_reg, mid_next;
    logic [NW-1:0] sel_reg, sel_next;

    // pending result and output register
    logic [7:0]  rsym_reg, rsym_next;
    freq_t       rfreq_reg, rfreq_next;
    freq_t       rlow_reg, rlow_next;
    status_t     rstat_reg, rstat_next;
    logic        ov_reg, ov_next;
    logic [7:0]  osym_reg, osym_next;
    freq_t       ofreq_reg, ofreq_next;
    freq_t       olow_reg, olow_next;
    status_t     ostat_reg, ostat_next;

    // RAM ports
    logic          u_we, u_wd, u_q, uq_vld_reg;
    logic [AW-1:0] u_wa, u_ra;
    logic          p_we;
    logic [AW-1:0] p_wa, p_ra;
    freq_t         p_wd, p_q;
    logic          c_we;
    logic [NW-1:0] c_wa, ca_ra, cb_ra;
    freq_t         c_wd, ca_q, cb_q;

    // divider
    logic  div_start, div_busy, div_done;
    ival_t div_a, div_b, div_q, div_r;

    // derived values
    logic [NW-1:0] n_eff;
    ival_t         tgt_eff;
    freq_t         total;
    logic          used_bit;
    freq_t         half;
    freq_t         run_sub;
    logic [NW:0]   lohi_sum;
    logic [17:0]   ri_dbl;
    logic          cfg_wr;

    always_comb
    begin
        if (ns_reg < 9'd2)
        begin
            n_eff = NW'(2);
        end
        else if (32'(ns_reg) > MAX_SYMBOLS)
        begin
            n_eff = NMAX;
        end
        else
        begin
            n_eff = NW'(ns_reg);
        end
    end

    assign tgt_eff  = (tr_reg < 17'd2) ? 17'd2 : tr_reg;
    assign total    = eff_total(lg_reg);
    // a mark never written reads as used
    assign used_bit = uq_vld_reg ? u_q : 1'b1;
    assign half     = {1'b0, p_q[15:1]} | 16'd1;
    assign run_sub  = run_reg - p_q;
    assign lohi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign ri_dbl   = {ri_reg, 1'b0};
    assign cfg_wr   = psel && penable && pwrite && pready;

    qfm_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(1)) u_used (
        .clk(clk), .we(u_we), .waddr(u_wa), .wdata(u_wd), .raddr(u_ra), .rdata(u_q)
    );

    qfm_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(16)) u_pend (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_q)
    );

    // cumulative table: two copies written together give two read ports
    qfm_ram #(.DEPTH(MAX_SYMBOLS + 1), .WIDTH(16)) u_cum_a (
        .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(ca_ra), .rdata(ca_q)
    );

    qfm_ram #(.DEPTH(MAX_SYMBOLS + 1), .WIDTH(16)) u_cum_b (
        .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(cb_ra), .rdata(cb_q)
    );

    qfm_div #(.W(17)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
        .busy(div_busy), .done(div_done), .quot(div_q), .rem(div_r)
    );

    always_comb
    begin
        ns_next     = ns_reg;
        tr_next     = tr_reg;
        lg_next     = lg_reg;
        init_next   = init_reg;
        ri_next     = ri_reg;
        ul_next     = ul_reg;
        dl_next     = dl_reg;
        inc_next    = inc_reg;
        state_next  = state_reg;
        fn_next     = fn_reg;
        sym_next    = sym_reg;
        mark_next   = mark_reg;
        cumin_next  = cumin_reg;
        k_next      = k_reg;
        kd_next     = kd_reg;
        pv_next     = 1'b0;
        cnt_next    = cnt_reg;
        share_next  = share_reg;
        extra_next  = extra_reg;
        run_next    = run_reg;
        mis_next    = mis_reg;
        neg_next    = neg_reg;
        frinit_next = frinit_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        sel_next    = sel_reg;
        rsym_next   = rsym_reg;
        rfreq_next  = rfreq_reg;
        rlow_next   = rlow_reg;
        rstat_next  = rstat_reg;
        ov_next     = ov_reg;
        osym_next   = osym_reg;
        ofreq_next  = ofreq_reg;
        olow_next   = olow_reg;
        ostat_next  = ostat_reg;

        u_we      = 1'b0;
        u_wa      = AW'(sym_reg);
        u_wd      = mark_reg;
        u_ra      = k_reg[AW-1:0];
        p_we      = 1'b0;
        p_wa      = kd_reg[AW-1:0];
        p_wd      = half;
        p_ra      = k_reg[AW-1:0];
        c_we      = 1'b0;
        c_wa      = kd_reg;
        c_wd      = run_sub;
        ca_ra     = sel_reg;
        cb_ra     = sel_reg + NW'(1);
        div_start = 1'b0;
        div_a     = {1'b0, total};
        div_b     = 17'(cnt_reg);

        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end

        // sweep data path: acts on the entry read in the cycle before
        if (pv_reg)
        begin
            if (state_reg == S_CNT || state_reg == S_CNT_E)
            begin
                cnt_next = cnt_reg + NW'(used_bit);
            end
            else if (state_reg == S_FILL || state_reg == S_FILL_E)
            begin
                p_we = 1'b1;
                if (!used_bit)
                begin
                    p_wd = '0;
                end
                else if (extra_reg != '0)
                begin
                    p_wd       = share_reg + 16'd1;
                    extra_next = extra_reg - NW'(1);
                end
                else
                begin
                    p_wd = share_reg;
                end
            end
            else if (state_reg == S_WALK || state_reg == S_WALK_E)
            begin
                p_we     = 1'b1;
                c_we     = 1'b1;
                c_wd     = (kd_reg == '0) ? 16'd0 : run_sub;
                run_next = run_sub;
                if (!neg_reg)
                begin
                    if (half > mis_reg)
                    begin
                        neg_next = 1'b1;
                    end
                    else
                    begin
                        mis_next = mis_reg - half;
                    end
                end
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    fn_next    = in_ch.func;
                    sym_next   = in_ch.symbol;
                    mark_next  = in_ch.used;
                    cumin_next = in_ch.cum_freq;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                rsym_next  = sym_reg;
                rfreq_next = '0;
                rlow_next  = '0;
                rstat_next = ST_OK;
                state_next = S_RESULT;
                case (fn_reg)
                    FUNC_MARK:
                    begin
                        if (32'(sym_reg) >= MAX_SYMBOLS)
                        begin
                            rstat_next = ST_BAD_SYM;
                        end
                        else
                        begin
                            u_we = 1'b1;
                        end
                    end
                    FUNC_INIT:
                    begin
                        k_next     = '0;
                        cnt_next   = '0;
                        state_next = S_CNT;
                    end
                    default:
                    begin
                        if (!init_reg)
                        begin
                            rstat_next = ST_NO_INIT;
                        end
                        else if (fn_reg == FUNC_ENC)
                        begin
                            if (32'(sym_reg) >= 32'(n_eff))
                            begin
                                rstat_next = ST_BAD_SYM;
                            end
                            else
                            begin
                                sel_next   = NW'(sym_reg);
                                state_next = S_FETCH;
                            end
                        end
                        else if (cumin_reg >= total)
                        begin
                            rstat_next = ST_BAD_CUM;
                        end
                        else
                        begin
                            lo_next    = '0;
                            hi_next    = n_eff;
                            state_next = S_SRCH;
                        end
                    end
                endcase
            end
            S_CNT:
            begin
                pv_next = 1'b1;
                if (k_reg == n_eff - NW'(1))
                begin
                    state_next = S_CNT_E;
                end
                else
                begin
                    k_next = k_reg + NW'(1);
                end
            end
            S_CNT_E:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (cnt_reg == '0)
                begin
                    init_next  = 1'b0;
                    rstat_next = ST_NO_USED;
                    state_next = S_RESULT;
                end
                else
                begin
                    div_start  = 1'b1;
                    ri_next    = 17'(n_eff >> 4) | 17'd2;
                    dl_next    = '0;
                    state_next = S_DIVI;
                end
            end
            S_DIVI:
            begin
                if (div_done)
                begin
                    share_next = div_q[15:0];
                    extra_next = NW'(div_r);
                    k_next     = '0;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                pv_next = 1'b1;
                kd_next = k_reg;
                if (k_reg == n_eff - NW'(1))
                begin
                    state_next = S_FILL_E;
                end
                else
                begin
                    k_next = k_reg + NW'(1);
                end
            end
            S_FILL_E:
            begin
                frinit_next = 1'b1;
                state_next  = S_REB;
            end
            S_REB:
            begin
                if (dl_reg != '0)
                begin
                    // deferred part of the last rescale: bump increment only
                    inc_next = inc_reg + 16'd1;
                    ul_next  = dl_reg;
                    dl_next  = '0;
                    if (frinit_reg)
                    begin
                        init_next  = 1'b1;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_UPD;
                    end
                end
                else
                begin
                    if (ri_reg != tgt_eff)
                    begin
                        ri_next = (ri_dbl > {1'b0, tgt_eff}) ? tgt_eff : ri_dbl[16:0];
                    end
                    run_next   = total;
                    mis_next   = total;
                    neg_next   = 1'b0;
                    k_next     = n_eff - NW'(1);
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                pv_next = 1'b1;
                kd_next = k_reg;
                if (k_reg == '0)
                begin
                    state_next = S_WALK_E;
                end
                else
                begin
                    k_next = k_reg - NW'(1);
                end
            end
            S_WALK_E:
            begin
                state_next = S_CTOP;
            end
            S_CTOP:
            begin
                c_we       = 1'b1;
                c_wa       = n_eff;
                c_wd       = total;
                div_start  = 1'b1;
                div_a      = neg_reg ? 17'd0 : {1'b0, mis_reg};
                div_b      = ri_reg;
                state_next = S_DIVM;
            end
            S_DIVM:
            begin
                if (div_done)
                begin
                    inc_next = div_q[15:0];
                    dl_next  = div_r;
                    ul_next  = ri_reg - div_r;
                    if (frinit_reg)
                    begin
                        init_next  = 1'b1;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_UPD;
                    end
                end
            end
            S_SRCH:
            begin
                if ({1'b0, lo_reg} + {{NW{1'b0}}, 1'b1} < {1'b0, hi_reg})
                begin
                    mid_next   = lohi_sum[NW:1];
                    ca_ra      = lohi_sum[NW:1];
                    state_next = S_SCMP;
                end
                else
                begin
                    sel_next   = lo_reg;
                    state_next = S_FETCH;
                end
            end
            S_SCMP:
            begin
                if (cumin_reg < ca_q)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_FETCH:
            begin
                state_next = S_GRAB;
            end
            S_GRAB:
            begin
                rsym_next  = 8'(sel_reg);
                rlow_next  = ca_q;
                rfreq_next = cb_q - ca_q;
                if (ul_reg == '0)
                begin
                    frinit_next = 1'b0;
                    state_next  = S_REB;
                end
                else
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (ul_reg != '0)
                begin
                    ul_next = ul_reg - 17'd1;
                end
                p_ra       = sel_reg[AW-1:0];
                state_next = S_PADD;
            end
            S_PADD:
            begin
                p_we       = 1'b1;
                p_wa       = sel_reg[AW-1:0];
                p_wd       = p_q + inc_reg;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next    = 1'b1;
                    osym_next  = rsym_reg;
                    ofreq_next = rfreq_reg;
                    olow_next  = rlow_reg;
                    ostat_next = rstat_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a write to any of the three config registers drops the model back to uninitialized
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_NUM_SYMBOLS:
                begin
                    ns_next   = pwdata[8:0];
                    init_next = 1'b0;
                end
                REG_TARGET:
                begin
                    tr_next   = pwdata[16:0];
                    init_next = 1'b0;
                end
                REG_LG_TOTAL:
                begin
                    lg_next   = pwdata[4:0];
                    init_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_reg     <= 9'd256;
            tr_reg     <= 17'd1024;
            lg_reg     <= 5'd16;
            init_reg   <= 1'b0;
            ri_reg     <= '0;
            ul_reg     <= '0;
            dl_reg     <= '0;
            inc_reg    <= '0;
            uvld_reg   <= '0;
            state_reg  <= S_IDLE;
            pv_reg     <= 1'b0;
            frinit_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            ns_reg     <= ns_next;
            tr_reg     <= tr_next;
            lg_reg     <= lg_next;
            init_reg   <= init_next;
            ri_reg     <= ri_next;
            ul_reg     <= ul_next;
            dl_reg     <= dl_next;
            inc_reg    <= inc_next;
            if (u_we)
            begin
                uvld_reg[u_wa] <= 1'b1;
            end
            state_reg  <= state_next;
            pv_reg     <= pv_next;
            frinit_reg <= frinit_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        uq_vld_reg <= uvld_reg[u_ra];
        fn_reg     <= fn_next;
        sym_reg    <= sym_next;
        mark_reg   <= mark_next;
        cumin_reg  <= cumin_next;
        k_reg      <= k_next;
        kd_reg     <= kd_next;
        cnt_reg    <= cnt_next;
        share_reg  <= share_next;
        extra_reg  <= extra_next;
        run_reg    <= run_next;
        mis_reg    <= mis_next;
        neg_reg    <= neg_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        sel_reg    <= sel_next;
        rsym_reg   <= rsym_next;
        rfreq_reg  <= rfreq_next;
        rlow_reg   <= rlow_next;
        rstat_reg  <= rstat_next;
        osym_reg   <= osym_next;
        ofreq_reg  <= ofreq_next;
        olow_reg   <= olow_next;
        ostat_reg  <= ostat_next;
    end

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = ov_reg;
    assign out_ch.symbol_out = osym_reg;
    assign out_ch.sym_freq   = ofreq_reg;
    assign out_ch.low_freq   = olow_reg;
    assign out_ch.status     = ostat_reg;

    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_NUM_SYMBOLS: prdata = {23'd0, ns_reg};
            REG_TARGET:      prdata = {15'd0, tr_reg};
            REG_LG_TOTAL:    prdata = {27'd0, lg_reg};
            default:         prdata = '0;
        endcase
    end

`ifndef SYNTH
    a_defer_below_interval: assert property (@(posedge clk) disable iff (!rst_n)
        dl_reg == '0 || dl_reg < ri_reg)
        else $error("deferred count not below rescale interval");

    a_extra_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL || state_reg == S_FILL_E) |-> extra_reg < cnt_reg)
        else $error("init remainder not below used count");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && ov_reg && !out_ch.ready) |=> state_reg == S_RESULT)
        else $error("result dropped while output slot full");

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !div_busy)
        else $error("divider busy while sequencer idle");
`endif

endmodule

[tb/quasistatic_frequency_model_test.sv]
// Self-checking testbench for the quasistatic frequency model: a behavioral
// predictor of the adaptive frequency tables checks every result beat in order.
// Depends on qfm_pkg, qfm_in_if, qfm_out_if and quasistatic_frequency_model.
module quasistatic_frequency_model_test;
    import qfm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSYM        = 256;
    localparam int WATCH_LIMIT = 4000;   // idle cycles allowed
    localparam int SETTLE      = 40;

    typedef struct packed {
        logic [7:0] symbol_out;
        freq_t      sym_freq;
        freq_t      low_freq;
        status_t    status;
    } coded_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    qfm_in_if  in_ch();
    qfm_out_if out_ch();

    quasistatic_frequency_model #(.MAX_SYMBOLS(NSYM)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // ---------------------------------------------------------------
    // Predictor state: its own copy of the tables and the registers
    // ---------------------------------------------------------------
    logic [15:0] pend_cnt [NSYM];
    logic [15:0] cum_tab  [NSYM+1];
    bit          use_mark [NSYM];
    int unsigned resc_ival;
    int unsigned upd_left;
    int unsigned defer_left;
    logic [15:0] incr;
    bit          model_ready;
    logic [8:0]  nsym_reg;
    logic [16:0] target_reg;
    logic [4:0]  lgtot_reg;

    coded_t expected_q[$];
    int     fail_count;
    int     idle_cycles;
    int     burst_left;

    // ---------------------------------------------------------------
    // Clock and reset
    // ---------------------------------------------------------------
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // effective register values (clamped as the block clamps them)
    function automatic int unsigned live_nsym();
        int unsigned n;
        n = nsym_reg;
        if (n < 2)
        begin
            n = 2;
        end
        if (n > NSYM)
        begin
            n = NSYM;
        end
        return n;
    endfunction

    function automatic int unsigned live_target();
        return (target_reg < 2) ? 2 : target_reg;
    endfunction

    function automatic int unsigned live_total();
        int unsigned lg;
        lg = lgtot_reg;
        if (lg < 8)
        begin
            lg = 8;
        end
        if (lg >= 16)
        begin
            return 65535;
        end
        return 1 << lg;
    endfunction

    // Rescale: either release the deferred remainder, or fold the pending
    // counts into a new cumulative table and halve them (x>>1 | 1).
    task automatic rebuild_tables();
        int unsigned n;
        int unsigned target;
        int unsigned total;
        logic [15:0] run;
        logic [15:0] cnt;
        logic [15:0] half;
        int          missing;
        int          k;
        n = live_nsym();
        target = live_target();
        total = live_total();
        if (defer_left != 0)
        begin
            incr = incr + 16'd1;
            upd_left = defer_left;
            defer_left = 0;
            return;
        end
        if (resc_ival != target)
        begin
            resc_ival = resc_ival << 1;
            if (resc_ival > target)
            begin
                resc_ival = target;
            end
        end
        run = total[15:0];
        missing = int'(total);
        for (k = int'(n) - 1; k > 0; k--)
        begin
            cnt = pend_cnt[k];
            half = (cnt >> 1) | 16'd1;
            run = run - cnt;        // wraps at 16 bits when overcommitted
            cum_tab[k] = run;
            pend_cnt[k] = half;
            missing -= int'(half);
        end
        pend_cnt[0] = (pend_cnt[0] >> 1) | 16'd1;
        missing -= int'(pend_cnt[0]);
        cum_tab[0] = 16'd0;
        cum_tab[n] = total[15:0];
        if (missing < 0)
        begin
            missing = 0;        // shortfall dropped on overcommit
        end
        incr = 16'(int'(missing) / int'(resc_ival));
        defer_left = int'(missing) % int'(resc_ival);
        upd_left = resc_ival - defer_left;
    endtask

    task automatic bump_symbol(input int unsigned sym);
        if (upd_left == 0)
        begin
            rebuild_tables();
        end
        if (upd_left != 0)
        begin
            upd_left--;
        end
        pend_cnt[sym] = pend_cnt[sym] + incr;
    endtask

    // Works out the result of one accepted request beat and updates the model.
    task automatic code_symbol(input func_t fn, input logic [7:0] sym, input logic mark,
                               input freq_t cum, output coded_t res);
        int unsigned n;
        int unsigned total;
        int unsigned used_cnt;
        int unsigned share;
        int unsigned extra;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned k;
        n = live_nsym();
        total = live_total();
        res = '{symbol_out: sym, sym_freq: '0, low_freq: '0, status: ST_OK};
        if (fn == FUNC_MARK)
        begin
            use_mark[sym] = mark;   // 8-bit symbol is always inside the mask
        end
        else if (fn == FUNC_INIT)
        begin
            used_cnt = 0;
            for (k = 0; k < n; k++)
            begin
                used_cnt += use_mark[k];
            end
            if (used_cnt == 0)
            begin
                model_ready = 1'b0;
                res.status = ST_NO_USED;
            end
            else
            begin
                share = total / used_cnt;
                extra = total % used_cnt;
                for (k = 0; k < n; k++)
                begin
                    if (use_mark[k] && extra != 0)
                    begin
                        pend_cnt[k] = 16'(share + 1);
                        extra--;
                    end
                    else if (use_mark[k])
                    begin
                        pend_cnt[k] = 16'(share);
                    end
                    else
                    begin
                        pend_cnt[k] = 16'd0;
                    end
                end
                resc_ival = (n >> 4) | 2;
                defer_left = 0;
                rebuild_tables();
                model_ready = 1'b1;
            end
        end
        else if (!model_ready)
        begin
            res.status = ST_NO_INIT;
        end
        else if (fn == FUNC_ENC)
        begin
            if (sym >= n)
            begin
                res.status = ST_BAD_SYM;
            end
            else
            begin
                res.low_freq = cum_tab[sym];
                res.sym_freq = cum_tab[sym + 1] - cum_tab[sym];
                bump_symbol(sym);
            end
        end
        else
        begin
            if (cum >= total)
            begin
                res.status = ST_BAD_CUM;
            end
            else
            begin
                lo = 0;
                hi = n;
                while (lo + 1 < hi)
                begin
                    mid = (lo + hi) >> 1;
                    if (cum < cum_tab[mid])
                    begin
                        hi = mid;
                    end
                    else
                    begin
                        lo = mid;
                    end
                end
                res.symbol_out = 8'(lo);
                res.low_freq = cum_tab[lo];
                res.sym_freq = cum_tab[lo + 1] - cum_tab[lo];
                bump_symbol(lo);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Result checker: every result beat against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        coded_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result beat with no prediction waiting");
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_ch.symbol_out !== want.symbol_out)
                begin
                    $error("symbol_out: expected %0d, got %0d", want.symbol_out,
                           out_ch.symbol_out);
                    fail_count++;
                end
                if (out_ch.sym_freq !== want.sym_freq)
                begin
                    $error("sym_freq: expected %0d, got %0d", want.sym_freq, out_ch.sym_freq);
                    fail_count++;
                end
                if (out_ch.low_freq !== want.low_freq)
                begin
                    $error("low_freq: expected %0d, got %0d", want.low_freq, out_ch.low_freq);
                    fail_count++;
                end
                if (out_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, out_ch.status);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: alternating stall and run stretches of random length;
    // a zero-length stall gives long stretches with ready held high.
    initial
    begin
        out_ch.ready = 1'b0;
    end

    always @(negedge clk)
    begin
        static int stall_len = 0;
        static int run_len = 0;
        if (stall_len > 0)
        begin
            out_ch.ready <= 1'b0;
            stall_len--;
        end
        else if (run_len > 0)
        begin
            out_ch.ready <= 1'b1;
            run_len--;
        end
        else
        begin
            stall_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            run_len = $urandom_range(1, 30);
            out_ch.ready <= (stall_len == 0);
            if (stall_len > 0)
            begin
                stall_len--;
            end
        end
    end

    // Watchdog: cycles with no beat and no register access
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("quasistatic_frequency_model_test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // One request beat. The sender works in bursts; between bursts valid
    // may drop for a random gap. Returns just after the accepting edge.
    task automatic send_req(input func_t fn, input logic [7:0] sym, input logic mark,
                            input freq_t cum);
        int     gap;
        coded_t res;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_ch.valid    <= 1'b1;
        in_ch.func     <= fn;
        in_ch.symbol   <= sym;
        in_ch.used     <= mark;
        in_ch.cum_freq <= cum;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        code_symbol(fn, sym, mark, cum, res);
        expected_q.push_back(res);
    endtask

    // Sender holds off until every predicted result has come back.
    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // APB write: setup then access; any write drops the init state.
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_NUM_SYMBOLS: nsym_reg = value[8:0];
            REG_TARGET:      target_reg = value[16:0];
            REG_LG_TOTAL:    lgtot_reg = value[4:0];
            default: ;
        endcase
        model_ready = 1'b0;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_model(input int unsigned n, input int unsigned tgt,
                             input int unsigned lg);
        drain_results();
        reg_write(REG_NUM_SYMBOLS, n);
        reg_write(REG_TARGET, tgt);
        reg_write(REG_LG_TOTAL, lg);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset defaults: not initialized, then a full-size model at 65535.
    task automatic test_reset_defaults();
        send_req(FUNC_ENC, 8'd0, 1'b0, 16'd0);
        send_req(FUNC_DEC, 8'd0, 1'b0, 16'hFFFF);      // not-initialized wins
        send_req(FUNC_MARK, 8'd255, 1'b0, 16'd0);
        send_req(FUNC_MARK, 8'd255, 1'b1, 16'd0);
        send_req(FUNC_INIT, 8'd0, 1'b0, 16'd0);
        send_req(FUNC_ENC, 8'd0, 1'b0, 16'd0);
        send_req(FUNC_ENC, 8'd255, 1'b0, 16'd0);
        send_req(FUNC_DEC, 8'd0, 1'b0, 16'd0);
        send_req(FUNC_DEC, 8'd0, 1'b0, 16'd65534);
        send_req(FUNC_DEC, 8'd0, 1'b0, 16'hFFFF);      // cum at total
    endtask

    // Two-symbol model: empty mask, bad symbol and bad cumulative value.
    task automatic test_edge_errors();
        set_model(2, 2, 8);
        send_req(FUNC_MARK, 8'd0, 1'b0, 16'd0);
        send_req(FUNC_MARK, 8'd1, 1'b0, 16'd0);
        send_req(FUNC_INIT, 8'd0, 1'b0, 16'd0);        // no used symbols
        send_req(FUNC_ENC, 8'd1, 1'b0, 16'd0);
        send_req(FUNC_MARK, 8'd0, 1'b1, 16'd0);
        send_req(FUNC_MARK, 8'd1, 1'b1, 16'd0);
        send_req(FUNC_INIT, 8'd0, 1'b0, 16'd0);
        send_req(FUNC_ENC, 8'd2, 1'b0, 16'd0);         // beyond num_symbols
        send_req(FUNC_ENC, 8'd1, 1'b0, 16'd0);
        send_req(FUNC_DEC, 8'd0, 1'b0, 16'd255);
        send_req(FUNC_DEC, 8'd0, 1'b0, 16'd256);       // too large for 2^8
        send_req(FUNC_DEC, 8'd0, 1'b0, 16'd128);
    endtask

    // One random phase under a given register setting. In a sparse phase
    // almost every symbol is masked first, which overcommits the halved
    // counts against a small total; the mask is restored afterward.
    task automatic test_random_phase(input int unsigned n, input int unsigned tgt,
                                     input int unsigned lg, input int items,
                                     input bit sparse);
        int unsigned nn;
        int unsigned total;
        int          pick;
        int          i;
        set_model(n, tgt, lg);
        nn = live_nsym();
        total = live_total();
        if (sparse)
        begin
            for (i = 0; i < NSYM; i++)
            begin
                send_req(FUNC_MARK, 8'(i), (i == 0) || ($urandom_range(0, 40) == 0), 16'd0);
            end
        end
        send_req(FUNC_INIT, 8'($urandom_range(0, 255)), 1'($urandom), 16'($urandom));
        for (i = 0; i < items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                send_req(FUNC_ENC, 8'($urandom_range(0, nn - 1)), 1'($urandom),
                         16'($urandom));
            end
            else if (pick < 50)
            begin
                send_req(FUNC_ENC, 8'($urandom_range(0, 255)), 1'($urandom), 16'($urandom));
            end
            else if (pick < 88)
            begin
                send_req(FUNC_DEC, 8'($urandom), 1'($urandom),
                         16'($urandom_range(0, total - 1)));
            end
            else if (pick < 91)
            begin
                send_req(FUNC_DEC, 8'($urandom), 1'($urandom), 16'($urandom));
            end
            else if (pick < 97)
            begin
                send_req(FUNC_MARK, 8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0,
                         16'($urandom));
            end
            else
            begin
                send_req(FUNC_INIT, 8'($urandom), 1'($urandom), 16'($urandom));
            end
        end
        if (sparse)
        begin
            for (i = 0; i < NSYM; i++)
            begin
                send_req(FUNC_MARK, 8'(i), 1'b1, 16'd0);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_MARK;
        in_ch.symbol = '0;
        in_ch.used = 1'b0;
        in_ch.cum_freq = '0;
        fail_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        for (int k = 0; k < NSYM; k++)
        begin
            use_mark[k] = 1'b1;
        end
        resc_ival = 0;
        upd_left = 0;
        defer_left = 0;
        incr = '0;
        model_ready = 1'b0;
        nsym_reg = 9'd256;
        target_reg = 17'd1024;
        lgtot_reg = 5'd16;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_edge_errors();
        test_random_phase(2, 2, 8, 70, 1'b0);
        test_random_phase(256, 131071, 16, 50, 1'b0);
        test_random_phase(0, 0, 0, 60, 1'b0);          // all clamped low
        test_random_phase(511, 1, 31, 70, 1'b0);       // count and total clamped high, target clamped low
        test_random_phase(37, 5, 12, 60, 1'b0);
        test_random_phase(100, 300, 16, 60, 1'b0);
        test_random_phase(256, 1024, 8, 40, 1'b1);
        test_random_phase(17, 131071, 9, 60, 1'b0);
        test_random_phase(256, 3, 16, 40, 1'b0);

        drain_results();
        if (fail_count == 0)
        begin
            $display("quasistatic_frequency_model_test passed");
        end
        else
        begin
            $display("quasistatic_frequency_model_test failed");
        end
        $finish;
    end

endmodule
